@@ rtl/core/jch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jch_pkg;

   // Field widths
   localparam int KEY_W    = 64;
   localparam int CNT_W    = 17;
   localparam int BUCKET_W = 16;

   // LCG key step: key = key * LCG_MULT + 1 (mod 2^64)
   localparam logic [KEY_W-1:0] LCG_MULT = 64'd2862933555777941757;
   localparam logic [KEY_W-1:0] LCG_INC  = 64'd1;

   // Jump step: j = ((b + 1) << JUMP_SHIFT) / ((key >> KEY_SHIFT) + 1)
   localparam int JUMP_SHIFT = 31;
   localparam int KEY_SHIFT  = 33;

   // Serial multiplier: one digit of the key per cycle
   localparam int DIGIT_W    = 4;
   localparam int LCG_STEPS  = KEY_W / DIGIT_W;
   localparam int LCG_CNT_W  = $clog2(LCG_STEPS);

   // Serial divider: one quotient bit per cycle
   localparam int NUM_W      = CNT_W + 1 + JUMP_SHIFT;
   localparam int DSR_W      = KEY_W - KEY_SHIFT + 1;
   localparam int QUO_W      = NUM_W;
   localparam int DIV_CNT_W  = $clog2(QUO_W);

   // Top level sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT
   } jch_state_type;

endpackage

`default_nettype wire

@@ rtl/core/jch_lcg.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Digit-serial LCG step: key * LCG_MULT + 1, one 4-bit key digit per cycle.
module jch_lcg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [jch_pkg::KEY_W-1:0] key_in,
   output logic                           done,
   output logic [jch_pkg::KEY_W-1:0]      key_out
);

   logic [jch_pkg::KEY_W-1:0]     mplier_ff, mplier_in;
   logic [jch_pkg::KEY_W-1:0]     mcand_ff, mcand_in;
   logic [jch_pkg::KEY_W-1:0]     acc_ff, acc_in;
   logic [jch_pkg::LCG_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [jch_pkg::KEY_W-1:0]     pp;

   // Partial product of the low key digit and the shifted multiplicand
   always_comb begin
      pp = '0;
      for (int i = 0; i < jch_pkg::DIGIT_W; i++) begin
         if (mplier_ff[i]) begin
            pp = pp + (mcand_ff << i);
         end
      end
   end

   // Shift-and-add sequencing
   always_comb begin
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (start) begin
         mplier_in = key_in;
         mcand_in  = jch_pkg::LCG_MULT;
         acc_in    = jch_pkg::LCG_INC;
         cnt_in    = '0;
         run_in    = 1'b1;
      end else if (run_ff) begin
         acc_in    = acc_ff + pp;
         mcand_in  = mcand_ff << jch_pkg::DIGIT_W;
         mplier_in = mplier_ff >> jch_pkg::DIGIT_W;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == jch_pkg::LCG_CNT_W'(jch_pkg::LCG_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign key_out = acc_ff;

endmodule

`default_nettype wire

@@ rtl/core/jch_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module jch_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [jch_pkg::NUM_W-1:0] dividend,
   input  wire logic [jch_pkg::DSR_W-1:0] divisor,
   output logic                           done,
   output logic [jch_pkg::QUO_W-1:0]      quotient
);

   logic [jch_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [jch_pkg::DSR_W-1:0]     dsr_ff, dsr_in;
   logic [jch_pkg::DSR_W-1:0]     rem_ff, rem_in;
   logic [jch_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [jch_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [jch_pkg::DSR_W:0]       trial;
   logic [jch_pkg::DSR_W:0]       diff;
   logic                          qbit;

   // Trial subtract of the divisor from the shifted remainder
   always_comb begin
      trial = {rem_ff, num_ff[jch_pkg::NUM_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      qbit  = (trial >= {1'b0, dsr_ff});
   end

   always_comb begin
      num_in  = num_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
         quo_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // remainder stays below the divisor, so the low bits hold it
         rem_in = qbit ? diff[jch_pkg::DSR_W-1:0] : trial[jch_pkg::DSR_W-1:0];
         quo_in = {quo_ff[jch_pkg::QUO_W-2:0], qbit};
         num_in = num_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == jch_pkg::DIV_CNT_W'(jch_pkg::QUO_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/core/jump_consistent_hash_bucket_unit.sv @@
// Jump consistent hash: maps a 64-bit key onto one of bucket_count buckets.
// A zero bucket count is answered in the cycle after the request is taken;
// otherwise each jump iteration runs the 4-bit-per-cycle LCG multiplier, then the
// 1-bit-per-cycle divider; about ln(count)+1 iterations. One request at a time.
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
// Reset (synchronous, active high) idles the unit and sets bucket_count to 1.
`timescale 1ns / 1ps
`default_nettype none

module jump_consistent_hash_bucket_unit #(
   parameter int MAX_BUCKETS = 65536
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [jch_pkg::KEY_W-1:0]    req_key,
   // result
   output logic                              rsp_valid,
   output logic [jch_pkg::BUCKET_W-1:0]      rsp_bucket,
   output logic                              rsp_no_bucket,
   // configuration
   input  wire logic                         csr_write_enable,
   input  wire logic [jch_pkg::CNT_W-1:0]    csr_write_data
);

   localparam logic [31:0]              MAX_W    = 32'(MAX_BUCKETS);
   localparam logic [jch_pkg::CNT_W-1:0] MAX_CLIP = jch_pkg::CNT_W'(MAX_BUCKETS);

   jch_pkg::jch_state_type state_ff, state_in;

   logic [jch_pkg::CNT_W-1:0]    bucket_count_ff, bucket_count_in;
   logic [jch_pkg::CNT_W-1:0]    count_sat;
   logic [jch_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [jch_pkg::CNT_W-1:0]    cand_ff, cand_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [jch_pkg::BUCKET_W-1:0] rsp_bucket_ff, rsp_bucket_in;
   logic                         rsp_no_bucket_ff, rsp_no_bucket_in;

   logic                         accept;
   logic                         mul_start, mul_done;
   logic [jch_pkg::KEY_W-1:0]    mul_key;
   logic                         div_start, div_done;
   logic [jch_pkg::NUM_W-1:0]    div_num;
   logic [jch_pkg::DSR_W-1:0]    div_dsr;
   logic [jch_pkg::QUO_W-1:0]    div_quo;
   logic                         jump_in_range;

   // Bucket count register, saturated at MAX_BUCKETS on use
   always_comb begin
      bucket_count_in = csr_write_enable ? csr_write_data : bucket_count_ff;
      count_sat = ({15'd0, bucket_count_ff} > MAX_W) ? MAX_CLIP : bucket_count_ff;
   end

   assign accept = start && !busy;

   // Serial units
   assign div_num = {1'b0, cand_ff + 1'b1, jch_pkg::JUMP_SHIFT'(0)};
   assign div_dsr = {1'b0, key_ff[jch_pkg::KEY_W-1:jch_pkg::KEY_SHIFT]} + 1'b1;
   assign jump_in_range = (div_quo < jch_pkg::QUO_W'(count_sat));

   jch_lcg u_lcg (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .key_in  (key_ff),
      .done    (mul_done),
      .key_out (mul_key)
   );

   jch_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jch_pkg::ST_IDLE: begin
            if (accept && (count_sat != '0)) begin
               state_in = jch_pkg::ST_MUL_GO;
            end
         end
         jch_pkg::ST_MUL_GO: begin
            state_in = jch_pkg::ST_MUL_WAIT;
         end
         jch_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = jch_pkg::ST_DIV_GO;
            end
         end
         jch_pkg::ST_DIV_GO: begin
            state_in = jch_pkg::ST_DIV_WAIT;
         end
         jch_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = jump_in_range ? jch_pkg::ST_MUL_GO : jch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jch_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      busy      = 1'b1;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         jch_pkg::ST_IDLE:     busy      = 1'b0;
         jch_pkg::ST_MUL_GO:   mul_start = 1'b1;
         jch_pkg::ST_MUL_WAIT: busy      = 1'b1;
         jch_pkg::ST_DIV_GO:   div_start = 1'b1;
         jch_pkg::ST_DIV_WAIT: busy      = 1'b1;
         default:              busy      = 1'b1;
      endcase
   end

   // Key, candidate and result registers
   always_comb begin
      key_in           = key_ff;
      cand_in          = cand_ff;
      rsp_valid_in     = 1'b0;
      rsp_bucket_in    = rsp_bucket_ff;
      rsp_no_bucket_in = rsp_no_bucket_ff;
      if (accept) begin
         key_in  = req_key;
         cand_in = '0;
         if (count_sat == '0) begin
            rsp_valid_in     = 1'b1;
            rsp_bucket_in    = '0;
            rsp_no_bucket_in = 1'b1;
         end
      end
      if ((state_ff == jch_pkg::ST_MUL_WAIT) && mul_done) begin
         key_in = mul_key;
      end
      if ((state_ff == jch_pkg::ST_DIV_WAIT) && div_done) begin
         if (jump_in_range) begin
            cand_in = div_quo[jch_pkg::CNT_W-1:0];
         end else begin
            rsp_valid_in     = 1'b1;
            rsp_bucket_in    = cand_ff[jch_pkg::BUCKET_W-1:0];
            rsp_no_bucket_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= jch_pkg::ST_IDLE;
         bucket_count_ff <= jch_pkg::CNT_W'(1);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bucket_count_ff <= bucket_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      key_ff           <= key_in;
      cand_ff          <= cand_in;
      rsp_bucket_ff    <= rsp_bucket_in;
      rsp_no_bucket_ff <= rsp_no_bucket_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bucket    = rsp_bucket_ff;
   assign rsp_no_bucket = rsp_no_bucket_ff;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_BUCKETS  = 65536;
   localparam int IDLE_LIMIT   = 20000;
   localparam int SETTLE_TAIL  = 150;

   typedef struct packed {
      logic [jch_pkg::BUCKET_W-1:0] bucket;
      logic                         no_bucket;
   } bucket_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [jch_pkg::KEY_W-1:0]    req_key = '0;
   logic                         rsp_valid;
   logic [jch_pkg::BUCKET_W-1:0] rsp_bucket;
   logic                         rsp_no_bucket;
   logic                         csr_write_enable = 1'b0;
   logic [jch_pkg::CNT_W-1:0]    csr_write_data = '0;

   // bucket count as the unit should currently hold it
   logic [jch_pkg::CNT_W-1:0]    bucket_count_model = 17'd1;
   bucket_result_type            expected_buckets[$];
   int                           mismatch_count = 0;
   int                           idle_cycles = 0;

   jump_consistent_hash_bucket_unit #(
      .MAX_BUCKETS(MAX_BUCKETS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_bucket      (rsp_bucket),
      .rsp_no_bucket   (rsp_no_bucket),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always #4 clock = ~clock;

   // jump consistent hash, exact integer division
   function automatic bucket_result_type jump_bucket_of(
         input logic [jch_pkg::KEY_W-1:0] key,
         input logic [jch_pkg::CNT_W-1:0] count);
      bucket_result_type         res;
      logic [63:0]               limit;
      logic [63:0]               cand;
      logic [63:0]               next_jump;
      logic [jch_pkg::KEY_W-1:0] state;
      limit = (count > MAX_BUCKETS) ? 64'(MAX_BUCKETS) : 64'(count);
      res.bucket    = '0;
      res.no_bucket = 1'b0;
      if (limit == 0) begin
         res.no_bucket = 1'b1;
         return res;
      end
      cand      = '0;
      next_jump = '0;
      state     = key;
      while (next_jump < limit) begin
         cand      = next_jump;
         state     = state * jch_pkg::LCG_MULT + jch_pkg::LCG_INC;
         next_jump = ((cand + 64'd1) << jch_pkg::JUMP_SHIFT)
                     / ((state >> jch_pkg::KEY_SHIFT) + 64'd1);
      end
      res.bucket = cand[jch_pkg::BUCKET_W-1:0];
      return res;
   endfunction

   // result checker: oldest expectation against each strobe
   always @(posedge clock) begin
      bucket_result_type exp_res;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_buckets.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected result bucket=%0d no_bucket=%0b",
                        $time, rsp_bucket, rsp_no_bucket);
            mismatch_count++;
         end else begin
            exp_res = expected_buckets.pop_front();
            if (rsp_bucket !== exp_res.bucket || rsp_no_bucket !== exp_res.no_bucket) begin
               if (mismatch_count < 10)
                  $display("%0t: mismatch bucket exp=%0d got=%0d, no_bucket exp=%0b got=%0b",
                           $time, exp_res.bucket, rsp_bucket, exp_res.no_bucket,
                           rsp_no_bucket);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // issue one request and hold it until accepted
   task automatic send_key(input logic [jch_pkg::KEY_W-1:0] key);
      @(negedge clock);
      start   = 1'b1;
      req_key = key;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_buckets.push_back(jump_bucket_of(key, bucket_count_model));
   endtask

   // stop issuing and wait for every outstanding result
   task automatic wait_for_idle();
      @(negedge clock);
      start = 1'b0;
      while (expected_buckets.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_bucket_count(input logic [jch_pkg::CNT_W-1:0] value);
      wait_for_idle();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      bucket_count_model = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data   = jch_pkg::CNT_W'($urandom);
   endtask

   // count of one straight out of reset
   task automatic test_reset_count();
      send_key('0);
      send_key('1);
      send_key(64'h8000_0000_0000_0000);
   endtask

   task automatic test_no_buckets();
      set_bucket_count('0);
      send_key('0);
      send_key('1);
      send_key({$urandom, $urandom});
   endtask

   // counts above, at and just below the bucket limit; those above saturate
   task automatic test_count_extremes();
      set_bucket_count(17'h1FFFF);
      send_key('0);
      send_key('1);
      set_bucket_count(17'd65537);
      send_key(64'h0000_0000_0000_0001);
      set_bucket_count(17'd65536);
      send_key(64'h8000_0000_0000_0000);
      send_key({$urandom, $urandom});
      set_bucket_count(17'd65535);
      send_key('1);
      send_key({$urandom, $urandom});
   endtask

   task automatic test_small_counts();
      set_bucket_count(17'd2);
      send_key('0);
      send_key('1);
      send_key({$urandom, $urandom});
      set_bucket_count(17'd3);
      send_key('0);
      send_key({$urandom, $urandom});
      set_bucket_count(17'd1);
      send_key({$urandom, $urandom});
   endtask

   // random counts, mostly small; random keys in bursts
   task automatic test_random();
      int                        phase_items;
      int                        burst_left;
      int                        gap;
      int                        sel;
      logic [jch_pkg::KEY_W-1:0] key;
      logic [jch_pkg::CNT_W-1:0] count;
      burst_left = 0;
      for (int phase = 0; phase < 15; phase++) begin
         sel = $urandom_range(99, 0);
         phase_items = 100;
         if (sel < 8)       count = '0;
         else if (sel < 18) count = 17'd1;
         else if (sel < 70) count = jch_pkg::CNT_W'($urandom_range(64, 2));
         else if (sel < 88) count = jch_pkg::CNT_W'($urandom_range(4096, 65));
         else begin
            count = jch_pkg::CNT_W'($urandom_range(131071, 4097));
            phase_items = 20;
         end
         set_bucket_count(count);
         for (int i = 0; i < phase_items; i++) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1);
               if (gap != 0) begin
                  @(negedge clock);
                  start = 1'b0;
                  repeat (gap - 1) @(negedge clock);
               end
               burst_left = $urandom_range(16, 1);
            end
            sel = $urandom_range(9, 0);
            if (sel == 0)      key = '0;
            else if (sel == 1) key = '1;
            else if (sel == 2) key = 64'd1 << $urandom_range(63, 0);
            else               key = {$urandom, $urandom};
            send_key(key);
            burst_left--;
            // occasionally let everything drain mid phase
            if ($urandom_range(49, 0) == 0) wait_for_idle();
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_count();
      test_no_buckets();
      test_count_extremes();
      test_small_counts();
      test_random();
      wait_for_idle();
      repeat (SETTLE_TAIL) @(posedge clock);
      if (expected_buckets.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
